>>> hdl/bts_pkg.sv
// shared types and codes for the byte table binary search unit
`timescale 1ns / 1ps

package bts_pkg;

  // request operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // one search result
  typedef struct packed {
    logic       found;
    logic [7:0] position;
  } result_t;

endpackage

>>> hdl/bts_ram.sv
// byte table storage, one write port and one registered read port
`timescale 1ns / 1ps

module bts_ram #(
  parameter int TABLE_DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bts_search.sv
// request handling and binary search sequencer over the table memory
`timescale 1ns / 1ps

module bts_search
  import bts_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          operation,
  input  logic [7:0]    entry_index,
  input  logic [7:0]    byte_value,
  input  logic [CW-1:0] count,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata,
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] low;
  logic [CW-1:0] low_next;
  logic [CW-1:0] hi;          // one past the high bound
  logic [CW-1:0] hi_next;
  logic [7:0]    key;
  result_t       pending;
  result_t       pending_next;
  logic [CW-1:0] mid;
  logic [CW-1:0] mid_inc;
  logic          accept;
  logic          slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign mid     = low + ((hi - low - CW'(1)) >> 1);
  assign mid_inc = mid + CW'(1);

  // writes go straight to the table, out of range indexes dropped
  assign mem_we    = accept && (operation == OP_WRITE)
                     && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign mem_waddr = AW'(entry_index);
  assign mem_wdata = byte_value;
  assign mem_re    = (state == ST_PROBE);
  assign mem_raddr = AW'(mid);

  always_comb begin
    state_next   = state;
    low_next     = low;
    hi_next      = hi;
    pending_next = pending;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_SEARCH)) begin
          low_next              = '0;
          hi_next               = count;
          pending_next.found    = 1'b0;
          pending_next.position = '0;
          state_next            = (count == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        priority if (mem_rdata == key) begin
          pending_next.found    = 1'b1;
          pending_next.position = 8'(mid);
          state_next            = ST_DONE;
        end else if (mem_rdata < key) begin
          low_next   = mid_inc;
          state_next = (mid_inc >= hi) ? ST_DONE : ST_PROBE;
        end else begin
          hi_next    = mid;
          state_next = (mid <= low) ? ST_DONE : ST_PROBE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low     <= low_next;
    hi      <= hi_next;
    pending <= pending_next;
    if (accept) begin
      key <= byte_value;
    end
    if ((state == ST_DONE) && slot_free) begin
      result <= pending;
    end
  end

endmodule

>>> hdl/byte_table_binary_search_unit.sv
// top level of the byte table binary search unit
`timescale 1ns / 1ps

// Holds a table of TABLE_DEPTH byte entries, kept sorted ascending by the
// user, in one synchronous memory. A write request (operation 0) stores
// byte_value at entry_index and gives no result; an index at or above
// TABLE_DEPTH is dropped. A search request (operation 1) looks up byte_value
// among entries 0 to entry_count-1 (entry_count is clamped to TABLE_DEPTH,
// zero gives an empty search) and returns one result: found and the matching
// position, or found clear with position 0. Each probe reads the table
// through its registered read port and then compares and narrows the
// bounds; a search makes up to ceil(log2(count+1)) probes and then posts the
// result from its done state. One request is in work at a time, so table
// writes and search reads never overlap. A finished result waits in the
// output register while the next request is accepted; a search that ends
// while that register is still full holds until it is taken. Entries read by
// a search must have been written since reset; there is no clearing pass.
// entry_count resets to 1 and is written through cfg_write/cfg_data; it must
// be written only while the unit is idle, which the unit does not enforce.

module byte_table_binary_search_unit
  import bts_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] entry_index,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       found,
  output logic [7:0] position,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data
);

  // table address width and width of a bound that can hold the depth itself
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [8:0]    entry_count;
  logic [CW-1:0] count_eff;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  result_t       result;

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 9'd1;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // clamp the count to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      count_eff = CW'(TABLE_DEPTH);
    end else begin
      count_eff = CW'(entry_count);
    end
  end

  // sequencer: request handshake, bounds, compare, result register
  bts_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .entry_index (entry_index),
    .byte_value  (byte_value),
    .count       (count_eff),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  // table storage
  bts_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result fields out to the ports
  assign found    = result.found;
  assign position = result.position;

endmodule

>>> hdl/bts_checker.sv
// port level checks for the byte table binary search unit, with its bind
`timescale 1ns / 1ps

module bts_checker
  import bts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [7:0] position
);

  // a result that is not taken holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
    else $error("result changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == 8'd0)
    else $error("miss with nonzero position");

  // a write request gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_WRITE) && !out_valid |=> !out_valid)
    else $error("result after a write request");

  // a search keeps the unit busy in the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_SEARCH) |=> !in_ready)
    else $error("request taken during a search");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind byte_table_binary_search_unit bts_checker u_bts_checker (.*);
